@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the ring buffer RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define ORB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ORB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/orb_pkg.sv @@
`timescale 1ns / 1ps
// Types, constants and helper functions for the overwriting ring buffer.
// No dependencies; used by orb_slot_div and overwrite_ring_buffer_lost_count.
package orb_pkg;

  localparam int ORB_DEPTH   = 1024;
  localparam int ORB_AW      = (ORB_DEPTH > 1) ? $clog2(ORB_DEPTH) : 1;
  localparam int CAP_W       = 11;
  localparam int CNT_W       = 64;
  localparam int OUT_TDATA_W = 88;

  typedef logic [CAP_W-1:0]       cap_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [OUT_TDATA_W-1:0] out_data_t;

  localparam cap_t CAP_RESET = cap_t'(1024);

  // Request kinds carried on in_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_CLAMP,
    ST_UPD,
    ST_OUT,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic start;
    cap_t cap;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    cap_t w_slot;
    cap_t r_slot;
  } div_res_t;

  // Zero behaves as one, anything above the ring depth saturates
  function automatic cap_t eff_cap(input cap_t raw);
    cap_t c;
    c = raw;
    if (raw == '0) begin
      c = cap_t'(1);
    end else if (raw > cap_t'(ORB_DEPTH)) begin
      c = cap_t'(ORB_DEPTH);
    end
    return c;
  endfunction

  function automatic cap_t next_slot(input cap_t slot, input cap_t cap);
    logic [CAP_W:0] s;
    s = {1'b0, slot} + {{CAP_W{1'b0}}, 1'b1};
    return (s == {1'b0, cap}) ? '0 : s[CAP_W-1:0];
  endfunction

  // One restoring step of a remainder by the capacity
  function automatic cap_t mod_step(input cap_t rem, input logic b, input cap_t cap);
    logic [CAP_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, cap}) begin
      t = t - {1'b0, cap};
    end
    return t[CAP_W-1:0];
  endfunction

endpackage

@@ rtl/core/orb_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module orb_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/orb_slot_div.sv @@
`timescale 1ns / 1ps
// Bit-serial remainder unit: recomputes write and read slots as position mod capacity.
// Depends on orb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orb_slot_div (
  input  logic              clk,
  input  logic              rst_n,
  input  orb_pkg::div_req_t req,
  input  orb_pkg::cnt_t     wc,
  input  orb_pkg::cnt_t     rc,
  output orb_pkg::div_res_t res
);

  logic                busy_r;
  logic                done_r;
  logic [5:0]          idx_r;
  orb_pkg::cap_t       cap_r;
  orb_pkg::cap_t       wrem_r;
  orb_pkg::cap_t       rrem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        idx_r  <= 6'(orb_pkg::CNT_W - 1);
      end else if (busy_r) begin
        if (idx_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r - 6'd1;
        end
      end
    end
  end

  // Walk both positions from the top bit down
  always_ff @(posedge clk) begin
    if (req.start) begin
      cap_r  <= req.cap;
      wrem_r <= '0;
      rrem_r <= '0;
    end else if (busy_r) begin
      wrem_r <= orb_pkg::mod_step(wrem_r, wc[idx_r], cap_r);
      rrem_r <= orb_pkg::mod_step(rrem_r, rc[idx_r], cap_r);
    end
  end

  assign res.busy   = busy_r;
  assign res.done   = done_r;
  assign res.w_slot = wrem_r;
  assign res.r_slot = rrem_r;

  `ORB_ASSERT(a_done_after_busy, done_r |-> $past(busy_r), "slot pass finished without running")

endmodule

@@ rtl/core/overwrite_ring_buffer_lost_count.sv @@
`timescale 1ns / 1ps
// Top level of the overwriting byte ring buffer with lost-byte counter.
// Depends on orb_pkg, orb_ram, orb_slot_div and assert_macros.svh.
//
// A byte ring that overwrites rather than stalling the writer when full: a write
// beat stores one byte, a read beat first skips over bytes already overwritten
// (adding them to the lost total) and then returns the oldest unread byte if
// there is one. Every input beat gives one result beat. Each item passes through
// these steps in order: the accepting state, the retained-window bound, the
// read-position clamp, the update with its single RAM access, and the result
// register; the 64-bit position arithmetic is split over these steps. A result
// waiting on out_tready does not stop the next item from being accepted. A write
// to the capacity register starts a pass that works out both slot indexes
// (position mod capacity) one bit a cycle; in_tready stays low during it.
`include "assert_macros.svh"

module overwrite_ring_buffer_lost_count (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] data_byte
  input  logic                       in_tuser,   // [0] req_type
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output orb_pkg::out_data_t         out_tdata,  // [7:0] read_data, [18:8] bytes_available,
                                                 // [82:19] lost_total, [87:83] zero
  output logic                       out_tuser,  // [0] read_valid
  input  logic                       cfg_wr_en,
  input  orb_pkg::cap_t              cfg_wr_data
);

  orb_pkg::state_t   state_r;
  orb_pkg::state_t   state_nxt;
  orb_pkg::cap_t     cap_raw_r;
  orb_pkg::cap_t     cap_eff;
  orb_pkg::cnt_t     wc_r;
  orb_pkg::cnt_t     rc_r;
  orb_pkg::cnt_t     lost_r;
  orb_pkg::cnt_t     oldest_r;
  orb_pkg::cnt_t     gap_r;
  orb_pkg::cap_t     w_slot_r;
  orb_pkg::cap_t     r_slot_r;
  orb_pkg::cap_t     avail_r;
  orb_pkg::cap_t     avail_pre;
  logic              kind_r;
  logic              lt_r;
  logic              gt_r;
  logic              rvalid_r;
  logic              out_tvalid_r;
  orb_pkg::out_data_t out_data_r;
  logic              out_user_r;

  logic              in_acc;
  logic              ram_we;
  logic              ram_re;
  logic              out_load;
  logic [7:0]        ram_rdata;
  logic [7:0]        rd_byte;
  logic              at_idle;
  logic              at_out;
  logic              slots_ok;

  orb_pkg::div_req_t div_req;
  orb_pkg::div_res_t div_res;

  assign cap_eff   = orb_pkg::eff_cap(cap_raw_r);
  assign in_acc    = in_tvalid && in_tready;
  assign avail_pre = wc_r[orb_pkg::CAP_W-1:0] - rc_r[orb_pkg::CAP_W-1:0];

  assign div_req.start = cfg_wr_en;
  assign div_req.cap   = orb_pkg::eff_cap(cfg_wr_data);

  orb_slot_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .wc    (wc_r),
    .rc    (rc_r),
    .res   (div_res)
  );

  orb_ram #(
    .DEPTH (orb_pkg::ORB_DEPTH),
    .AW    (orb_pkg::ORB_AW),
    .DW    (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_slot_r[orb_pkg::ORB_AW-1:0]),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (r_slot_r[orb_pkg::ORB_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      orb_pkg::ST_IDLE:  if (in_acc) state_nxt = orb_pkg::ST_OLD;
      orb_pkg::ST_OLD:   state_nxt = orb_pkg::ST_CLAMP;
      orb_pkg::ST_CLAMP: state_nxt = orb_pkg::ST_UPD;
      orb_pkg::ST_UPD:   state_nxt = orb_pkg::ST_OUT;
      orb_pkg::ST_OUT:   if (!out_tvalid_r || out_tready) state_nxt = orb_pkg::ST_IDLE;
      orb_pkg::ST_MOD:   if (div_res.done) state_nxt = orb_pkg::ST_IDLE;
      default:           state_nxt = orb_pkg::ST_IDLE;
    endcase
    if (cfg_wr_en) begin
      state_nxt = orb_pkg::ST_MOD;
    end
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      orb_pkg::ST_IDLE: in_tready = !cfg_wr_en;
      orb_pkg::ST_UPD:  ram_re = (kind_r == orb_pkg::REQ_READ) && (avail_pre != '0);
      orb_pkg::ST_OUT:  out_load = !out_tvalid_r || out_tready;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign ram_we = in_acc && (in_tuser == orb_pkg::REQ_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= orb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_raw_r <= orb_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_raw_r <= cfg_wr_data;
    end
  end

  // Positions, slots and the lost total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r     <= '0;
      rc_r     <= '0;
      lost_r   <= '0;
      w_slot_r <= '0;
      r_slot_r <= '0;
    end else begin
      case (state_r)
        orb_pkg::ST_IDLE: begin
          if (ram_we) begin
            wc_r     <= wc_r + orb_pkg::cnt_t'(1);
            w_slot_r <= orb_pkg::next_slot(w_slot_r, cap_eff);
          end
        end
        orb_pkg::ST_CLAMP: begin
          // Pull the read position into the retained window
          if (kind_r == orb_pkg::REQ_READ) begin
            if (rc_r < oldest_r) begin
              rc_r     <= oldest_r;
              r_slot_r <= w_slot_r;
            end else if (gt_r) begin
              rc_r     <= wc_r;
              r_slot_r <= w_slot_r;
            end
          end
        end
        orb_pkg::ST_UPD: begin
          if (kind_r == orb_pkg::REQ_READ) begin
            if (lt_r) begin
              lost_r <= lost_r + gap_r;
            end
            if (ram_re) begin
              rc_r     <= rc_r + orb_pkg::cnt_t'(1);
              r_slot_r <= orb_pkg::next_slot(r_slot_r, cap_eff);
            end
          end
        end
        orb_pkg::ST_MOD: begin
          if (div_res.done) begin
            w_slot_r <= div_res.w_slot;
            r_slot_r <= div_res.r_slot;
          end
        end
        default: begin
          lost_r <= lost_r;
        end
      endcase
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_tuser;
    end
    if (state_r == orb_pkg::ST_OLD) begin
      oldest_r <= (wc_r > orb_pkg::cnt_t'(cap_eff)) ? wc_r - orb_pkg::cnt_t'(cap_eff) : '0;
      gt_r     <= rc_r > wc_r;
    end
    if (state_r == orb_pkg::ST_CLAMP) begin
      lt_r  <= rc_r < oldest_r;
      gap_r <= oldest_r - rc_r;
    end
    if (state_r == orb_pkg::ST_UPD) begin
      if (kind_r == orb_pkg::REQ_READ) begin
        rvalid_r <= ram_re;
        avail_r  <= ram_re ? avail_pre - orb_pkg::cap_t'(1) : avail_pre;
      end else begin
        rvalid_r <= 1'b0;
        if (lt_r) begin
          avail_r <= cap_eff;
        end else if (gt_r) begin
          avail_r <= '0;
        end else begin
          avail_r <= avail_pre;
        end
      end
    end
  end

  // Result register: hold until taken, refill behind a taken beat
  assign rd_byte = rvalid_r ? ram_rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= orb_pkg::out_data_t'({lost_r, avail_r, rd_byte});
      out_user_r <= rvalid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign at_idle  = (state_r == orb_pkg::ST_IDLE);
  assign at_out   = (state_r == orb_pkg::ST_OUT);
  assign slots_ok = (w_slot_r < cap_eff) && (r_slot_r < cap_eff);

  `ORB_ASSERT(a_slots_in_range, at_idle |-> slots_ok, "slot index outside capacity")
  `ORB_ASSERT(a_result_from_out, $rose(out_tvalid_r) |-> $past(at_out), "stray result beat")
  `ORB_ASSERT(a_avail_capped, at_out |-> (avail_r <= cap_eff), "available above capacity")
  `ORB_ASSERT(a_div_idle, at_idle |-> !div_res.busy, "slot pass running while idle")
  `ORB_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (at_idle && !out_tvalid_r), "busy after reset")

endmodule
